### design/gbc_pkg.sv
// Shared types, constants and round functions for the GOST ECB block cipher.
package gbc_pkg;

  localparam int unsigned Rounds    = 32;
  localparam int unsigned FwdRounds = 24;
  localparam int unsigned Rot       = 11;
  localparam int unsigned KeyWords  = 8;

  typedef logic [31:0] word_t;
  typedef logic [KeyWords-1:0][31:0] key_array_t;
  typedef logic [$clog2(KeyWords)-1:0] key_idx_t;

  typedef struct packed {
    logic valid;
    logic dec;
  } cell_ctl_t;

  typedef logic [3:0] nib_t;
  typedef nib_t [15:0] sbox_row_t;

  localparam sbox_row_t SBOX [KeyWords] = '{
    '{4'h3, 4'h8, 4'hB, 4'h1, 4'hD, 4'hE, 4'h9, 4'h7,
      4'h0, 4'h5, 4'h4, 4'h6, 4'hA, 4'h2, 4'hC, 4'hF},
    '{4'h1, 4'h9, 4'hA, 4'h5, 4'h0, 4'h8, 4'hD, 4'h7,
      4'h2, 4'hE, 4'hF, 4'hC, 4'h4, 4'h3, 4'h6, 4'hB},
    '{4'h2, 4'h7, 4'h3, 4'h9, 4'h8, 4'h4, 4'hD, 4'hA,
      4'h5, 4'h6, 4'hE, 4'hF, 4'h0, 4'hB, 4'hC, 4'h1},
    '{4'h8, 4'hF, 4'h3, 4'h9, 4'h4, 4'hB, 4'h2, 4'h6,
      4'hD, 4'h0, 4'h7, 4'hA, 4'hC, 4'hE, 4'h5, 4'h1},
    '{4'h1, 4'hF, 4'hE, 4'h4, 4'h5, 4'h6, 4'h3, 4'h7,
      4'hB, 4'hA, 4'h2, 4'hD, 4'h9, 4'h8, 4'hC, 4'h0},
    '{4'h6, 4'hD, 4'h9, 4'hC, 4'h7, 4'h4, 4'hA, 4'h1,
      4'hB, 4'hE, 4'h5, 4'h2, 4'h3, 4'hF, 4'h0, 4'h8},
    '{4'h7, 4'h5, 4'hA, 4'hB, 4'h4, 4'hC, 4'h8, 4'hD,
      4'h2, 4'h9, 4'hE, 4'h1, 4'hF, 4'h6, 4'h0, 4'h3},
    '{4'hE, 4'h2, 4'hD, 4'h7, 4'h9, 4'h5, 4'h3, 4'hC,
      4'h4, 4'h0, 4'hB, 4'hF, 4'h8, 4'h6, 4'hA, 4'h1}
  };

  // S-box row k replaces nibble k, least significant first.
  function automatic word_t sbox_sub(input word_t x);
    word_t s;
    s = '0;
    for (int k = 0; k < KeyWords; k++) begin
      s[4*k +: 4] = SBOX[k][x[4*k +: 4]];
    end
    return s;
  endfunction

  function automatic word_t round_f(input word_t half, input word_t key);
    word_t sum;
    word_t s;
    sum = half + key;
    s   = sbox_sub(sum);
    return {s[31-Rot:0], s[31:32-Rot]};
  endfunction

  function automatic key_idx_t key_index(input logic dec, input int unsigned rnd);
    int unsigned fwd;
    key_idx_t    low;
    fwd = dec ? (Rounds - FwdRounds) : FwdRounds;
    low = key_idx_t'(rnd % KeyWords);
    if (rnd < fwd) begin
      return low;
    end
    return key_idx_t'(KeyWords - 1) - low;
  endfunction

endpackage

### design/gbc_round_cell.sv
// One Feistel round of the cipher with its pipeline register.
module gbc_round_cell #(
  parameter int unsigned ROUND = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  gbc_pkg::key_array_t key_words,
  input  gbc_pkg::cell_ctl_t  ctl_in,
  input  gbc_pkg::word_t      n1_in,
  input  gbc_pkg::word_t      n2_in,
  output gbc_pkg::cell_ctl_t  ctl_out,
  output gbc_pkg::word_t      n1_out,
  output gbc_pkg::word_t      n2_out
);
  import gbc_pkg::*;

  key_idx_t ksel;
  word_t    f;

  assign ksel = key_index(ctl_in.dec, ROUND);
  assign f    = round_f(n1_in, key_words[ksel]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.dec <= ctl_in.dec;
    n1_out      <= f ^ n2_in;
    n2_out      <= n1_in;
  end

endmodule

### design/gost_block_cipher_ecb.sv
// Top level: key registers and the 32-cell round pipeline.
// Usage:
//   Key: eight 32-bit words written through wr_en / wr_index / wr_data, one
//   word per cycle, no wait. Write the key only while no block is in flight.
//   Input: a block transfer happens on a rising edge with start high and
//   busy low. busy is always low, so a block may be offered every cycle.
//   action selects encrypt (0) or decrypt (1); block_in carries N1 in the
//   high word and N2 in the low word.
//   Output: block_out is valid for the single cycle in which done is high.
//   Path: each block passes through the round cells in order, each with its
//   own register; done is driven from the last cell's register.
//   Throughput: one block per cycle, each cell of the chain works on a
//   different block.
//   Reset: clears the key words and all in-flight blocks; no result is
//   produced for a block accepted before reset.
//   The receiver cannot stall; results must be taken when done is high.
module gost_block_cipher_ecb (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [63:0] block_in,
  output logic        done,
  output logic [63:0] block_out
);
  import gbc_pkg::*;

  key_array_t key_words;
  cell_ctl_t  ctl [Rounds+1];
  word_t      n1  [Rounds+1];
  word_t      n2  [Rounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_words <= '0;
    end else if (wr_en) begin
      key_words[wr_index] <= wr_data;
    end
  end

  assign busy         = 1'b0;
  assign ctl[0].valid = start & ~busy;
  assign ctl[0].dec   = action;
  assign n1[0]        = block_in[63:32];
  assign n2[0]        = block_in[31:0];

  for (genvar r = 0; r < Rounds; r++) begin : g_cell
    gbc_round_cell #(.ROUND(r)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key_words (key_words),
      .ctl_in    (ctl[r]),
      .n1_in     (n1[r]),
      .n2_in     (n2[r]),
      .ctl_out   (ctl[r+1]),
      .n1_out    (n1[r+1]),
      .n2_out    (n2[r+1])
    );
  end

  assign done      = ctl[Rounds].valid;
  assign block_out = {n2[Rounds], n1[Rounds]};

endmodule

### design/gbc_checker.sv
// Port-level checker for the cipher top level, with its bind.
module gbc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_quiet_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done straight after reset");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 32))
    else $error("done without a start transfer 32 cycles earlier");

  a_no_done_without_history: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done)) |-> ($past(start, 32) && $past(start, 33)))
    else $error("back-to-back results without back-to-back starts");

endmodule

bind gost_block_cipher_ecb gbc_checker u_gbc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
